>>> sv/length_prefixed_message_ring_defines.svh
// Assertion macros for the length-prefixed message ring.
// Included by the top level; expects clk and rst_n in scope where used.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define LPMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define LPMR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LPMR_ASSERT(label, prop, msg)
`define LPMR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> sv/lpmr_pkg.sv
// Shared types, codes and header byte helpers for the message ring.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpmr_pkg;

    // Action codes of an input item
    localparam logic [2:0] ACT_PUSH_START = 3'd0;
    localparam logic [2:0] ACT_PUSH_BYTE  = 3'd1;
    localparam logic [2:0] ACT_POP_HEADER = 3'd2;
    localparam logic [2:0] ACT_POP_BYTE   = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    // Status codes of a result item
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_EMPTY     = 3'd2;
    localparam logic [2:0] STS_TOO_LARGE = 3'd3;
    localparam logic [2:0] STS_SEQ       = 3'd4;

    // Width of a byte count and of a header byte index
    localparam int CNT_W  = 13;
    localparam int HIDX_W = 4;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic [11:0] msg_length;
        logic        last;
    } rsp_t;

    // Byte of a little-endian length header; bytes above the count are zero
    function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] count,
                                            input logic [HIDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = count[7:0];
            4'd1:    b = {3'b000, count[12:8]};
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Merge one header byte into the length being assembled
    function automatic logic [CNT_W-1:0] hdr_merge(input logic [CNT_W-1:0] acc,
                                                   input logic [7:0] data,
                                                   input logic [HIDX_W-1:0] idx);
        logic [CNT_W-1:0] r;
        case (idx)
            4'd0:    r = {acc[12:8], data};
            4'd1:    r = {data[4:0], acc[7:0]};
            default: r = acc;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/lpmr_ram.sv
// Byte store of the ring: one write port, one read port, registered read.
// Imports lpmr_pkg for house consistency only; nothing in it is used here.
`default_nettype none

module lpmr_ram
    import lpmr_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] ring_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    // Read one byte; the data is registered and appears in the following cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/lpmr_out_q.sv
// Two-entry result queue that parts the sequencer from the result channel.
// Depends on lpmr_pkg for the result item type.
`default_nettype none

module lpmr_out_q
    import lpmr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rsp_t push_data,
    output logic space,
    output logic valid,
    input  logic stall,
    output rsp_t head
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    rsp_t       head_reg;
    rsp_t       head_next;
    rsp_t       tail_reg;
    rsp_t       tail_next;
    logic       pop;

    assign valid = (count_reg != 2'd0);
    assign space = (count_reg != 2'd2);
    assign pop   = valid && !stall;
    assign head  = head_reg;

    // Advance the queue on push and pop
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (pop && push)
                begin
                    head_next = push_data;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
                else if (push)
                begin
                    tail_next  = push_data;
                    count_next = 2'd2;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                    if (push)
                    begin
                        tail_next = push_data;
                    end
                    else
                    begin
                        count_next = 2'd1;
                    end
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    // Hold the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the queued items
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

>>> sv/length_prefixed_message_ring.sv
// Channel  | Handshake           | Payload
// cmd      | cmd_valid/cmd_stall | action, data_byte, byte_count
// rsp      | rsp_valid/rsp_stall | status, out_byte, msg_length, last
//
// push_byte, clear and rejected items (full, empty, out of sequence) finish in
// idle; push_start writes header byte 0, then the rest in S_HDR_WR (one header
// byte written per cycle); pop_byte reads the store, then delivers in S_BYTE_RD;
// pop_header reads in S_HDR_RD, updates space in S_HDR_END. One item at a time.
// Reset clears positions and counts at once; the byte store has no clear.
// A stalled result waits in a two-entry queue; cmd_stall rises when it fills.
//
// Top level: sequencer around the byte store and the result queue.
// Depends on lpmr_pkg, lpmr_ram, lpmr_out_q and the assertion macro header.
`default_nettype none
`include "length_prefixed_message_ring_defines.svh"

module length_prefixed_message_ring
    import lpmr_pkg::*;
#(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [12:0] byte_count,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [7:0]  out_byte,
    output logic [11:0] msg_length,
    output logic        last
);

    localparam int PW = $clog2(RING_BYTES);
    localparam int FW = $clog2(RING_BYTES + 1);
    localparam int MW = $clog2(RING_BYTES / HEADER_BYTES + 1);
    localparam int SW = ((FW > CNT_W) ? FW : CNT_W) + 1;
    localparam logic [SW-1:0]     RING_S     = SW'(RING_BYTES);
    localparam logic [SW-1:0]     HDR_S      = SW'(HEADER_BYTES);
    localparam logic [HIDX_W-1:0] HDR_N      = HIDX_W'(HEADER_BYTES);
    localparam logic [HIDX_W-1:0] HDR_LAST   = HIDX_W'(HEADER_BYTES - 1);
    localparam logic [PW-1:0]     POS_LAST   = PW'(RING_BYTES - 1);
    localparam bit                HDR_NARROW = (HEADER_BYTES < 2);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_HDR_WR   = 3'd1;
    localparam logic [2:0] S_HDR_RD   = 3'd2;
    localparam logic [2:0] S_HDR_END  = 3'd3;
    localparam logic [2:0] S_BYTE_RD  = 3'd4;

    // Advance a ring position by one byte
    function automatic logic [PW-1:0] adv1(input logic [PW-1:0] pos);
        return (pos == POS_LAST) ? '0 : pos + PW'(1);
    endfunction

    // Advance a ring position by a whole record (never beyond one ring)
    function automatic logic [PW-1:0] advn(input logic [PW-1:0] pos,
                                           input logic [SW-1:0] n);
        logic [SW-1:0] sum;
        sum = SW'(pos) + n;
        if (sum >= RING_S)
        begin
            sum = sum - RING_S;
        end
        return sum[PW-1:0];
    endfunction

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [PW-1:0]     read_pos_reg;
    logic [PW-1:0]     read_pos_next;
    logic [PW-1:0]     write_pos_reg;
    logic [PW-1:0]     write_pos_next;
    logic [FW-1:0]     free_bytes_reg;
    logic [FW-1:0]     free_bytes_next;
    logic [MW-1:0]     message_count_reg;
    logic [MW-1:0]     message_count_next;
    logic [CNT_W-1:0]  push_left_reg;
    logic [CNT_W-1:0]  push_left_next;
    logic [CNT_W-1:0]  pop_left_reg;
    logic [CNT_W-1:0]  pop_left_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [HIDX_W-1:0] idx_reg;
    logic [HIDX_W-1:0] idx_next;
    logic [PW-1:0]     hdr_addr_reg;
    logic [PW-1:0]     hdr_addr_next;
    logic [CNT_W-1:0]  len_acc_reg;
    logic [CNT_W-1:0]  len_acc_next;

    logic          mem_wr_en;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [PW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    logic          q_push;
    rsp_t          q_data;
    logic          q_space;
    rsp_t          q_head;

    logic          cmd_take;
    logic [SW-1:0] start_need;
    logic          start_fits;
    logic [SW-1:0] rec_bytes;

    assign cmd_stall = (state_reg != S_IDLE) || !q_space;
    assign cmd_take  = cmd_valid && !cmd_stall;

    // Space check for a new message
    assign start_need = SW'(byte_count) + HDR_S;
    assign start_fits = (HDR_NARROW ? (byte_count[12:8] == 5'd0) : 1'b1)
                        && (start_need <= SW'(free_bytes_reg));
    assign rec_bytes  = SW'(len_acc_reg) + HDR_S;

    // Sequence each item over the store
    always_comb
    begin
        state_next         = state_reg;
        read_pos_next      = read_pos_reg;
        write_pos_next     = write_pos_reg;
        free_bytes_next    = free_bytes_reg;
        message_count_next = message_count_reg;
        push_left_next     = push_left_reg;
        pop_left_next      = pop_left_reg;
        cnt_next           = cnt_reg;
        idx_next           = idx_reg;
        hdr_addr_next      = hdr_addr_reg;
        len_acc_next       = len_acc_reg;
        mem_wr_en          = 1'b0;
        mem_wr_data        = 8'd0;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = read_pos_reg;
        q_push             = 1'b0;
        q_data             = '0;
        q_data.status      = STS_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    cnt_next = byte_count;
                    case (action)
                        ACT_PUSH_START:
                        begin
                            if (push_left_reg != '0)
                            begin
                                q_push        = 1'b1;
                                q_data.status = STS_SEQ;
                            end
                            else if (!start_fits)
                            begin
                                q_push        = 1'b1;
                                q_data.status = STS_FULL;
                            end
                            else
                            begin
                                // Reserve the record and write header byte 0
                                free_bytes_next = free_bytes_reg - FW'(start_need);
                                mem_wr_en       = 1'b1;
                                mem_wr_data     = hdr_byte(byte_count, '0);
                                write_pos_next  = adv1(write_pos_reg);
                                push_left_next  = byte_count;
                                if (byte_count == '0)
                                begin
                                    message_count_next = message_count_reg + MW'(1);
                                end
                                if (HEADER_BYTES == 1)
                                begin
                                    q_push = 1'b1;
                                end
                                else
                                begin
                                    idx_next   = HIDX_W'(1);
                                    state_next = S_HDR_WR;
                                end
                            end
                        end
                        ACT_PUSH_BYTE:
                        begin
                            q_push = 1'b1;
                            if (push_left_reg == '0)
                            begin
                                q_data.status = STS_SEQ;
                            end
                            else
                            begin
                                // Store a body byte; commit on the last one
                                mem_wr_en      = 1'b1;
                                mem_wr_data    = data_byte;
                                write_pos_next = adv1(write_pos_reg);
                                push_left_next = push_left_reg - CNT_W'(1);
                                if (push_left_reg == CNT_W'(1))
                                begin
                                    message_count_next = message_count_reg + MW'(1);
                                end
                            end
                        end
                        ACT_POP_HEADER:
                        begin
                            if (pop_left_reg != '0)
                            begin
                                q_push        = 1'b1;
                                q_data.status = STS_SEQ;
                            end
                            else if (message_count_reg == '0)
                            begin
                                q_push        = 1'b1;
                                q_data.status = STS_EMPTY;
                            end
                            else
                            begin
                                // Start reading the header
                                mem_rd_en     = 1'b1;
                                mem_rd_addr   = read_pos_reg;
                                hdr_addr_next = adv1(read_pos_reg);
                                idx_next      = HIDX_W'(1);
                                len_acc_next  = '0;
                                state_next    = S_HDR_RD;
                            end
                        end
                        ACT_POP_BYTE:
                        begin
                            if (pop_left_reg == '0)
                            begin
                                q_push        = 1'b1;
                                q_data.status = STS_SEQ;
                            end
                            else
                            begin
                                // Fetch a body byte and give back its space
                                mem_rd_en       = 1'b1;
                                mem_rd_addr     = read_pos_reg;
                                read_pos_next   = adv1(read_pos_reg);
                                free_bytes_next = free_bytes_reg + FW'(1);
                                pop_left_next   = pop_left_reg - CNT_W'(1);
                                state_next      = S_BYTE_RD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            q_push             = 1'b1;
                            read_pos_next      = '0;
                            write_pos_next     = '0;
                            free_bytes_next    = FW'(RING_BYTES);
                            message_count_next = '0;
                            push_left_next     = '0;
                            pop_left_next      = '0;
                        end
                        default:
                        begin
                            q_push        = 1'b1;
                            q_data.status = STS_SEQ;
                        end
                    endcase
                end
            end
            S_HDR_WR:
            begin
                // Write the remaining header bytes
                mem_wr_en      = 1'b1;
                mem_wr_data    = hdr_byte(cnt_reg, idx_reg);
                write_pos_next = adv1(write_pos_reg);
                idx_next       = idx_reg + HIDX_W'(1);
                if (idx_reg == HDR_LAST)
                begin
                    q_push     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HDR_RD:
            begin
                // Collect the byte read last cycle; issue the next read until the header is done
                len_acc_next = hdr_merge(len_acc_reg, mem_rd_data, idx_reg - HIDX_W'(1));
                if (idx_reg == HDR_N)
                begin
                    state_next = S_HDR_END;
                end
                else
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = hdr_addr_reg;
                    hdr_addr_next = adv1(hdr_addr_reg);
                    idx_next      = idx_reg + HIDX_W'(1);
                end
            end
            S_HDR_END:
            begin
                // Open the pop, or drop a record too large for the reader
                q_push             = 1'b1;
                q_data.msg_length  = len_acc_reg[11:0];
                message_count_next = message_count_reg - MW'(1);
                if (len_acc_reg > cnt_reg)
                begin
                    q_data.status   = STS_TOO_LARGE;
                    read_pos_next   = advn(read_pos_reg, rec_bytes);
                    free_bytes_next = free_bytes_reg + FW'(rec_bytes);
                end
                else
                begin
                    read_pos_next   = hdr_addr_reg;
                    free_bytes_next = free_bytes_reg + FW'(HEADER_BYTES);
                    pop_left_next   = len_acc_reg;
                end
                state_next = S_IDLE;
            end
            S_BYTE_RD:
            begin
                // Deliver the fetched byte
                q_push          = 1'b1;
                q_data.out_byte = mem_rd_data;
                q_data.last     = (pop_left_reg == '0);
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            read_pos_reg      <= '0;
            write_pos_reg     <= '0;
            free_bytes_reg    <= FW'(RING_BYTES);
            message_count_reg <= '0;
            push_left_reg     <= '0;
            pop_left_reg      <= '0;
            idx_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            read_pos_reg      <= read_pos_next;
            write_pos_reg     <= write_pos_next;
            free_bytes_reg    <= free_bytes_next;
            message_count_reg <= message_count_next;
            push_left_reg     <= push_left_next;
            pop_left_reg      <= pop_left_next;
            idx_reg           <= idx_next;
        end
    end

    // Hold working payload
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        hdr_addr_reg <= hdr_addr_next;
        len_acc_reg  <= len_acc_next;
    end

    lpmr_ram #(
        .DEPTH (RING_BYTES),
        .AW    (PW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lpmr_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .space     (q_space),
        .valid     (rsp_valid),
        .stall     (rsp_stall),
        .head      (q_head)
    );

    assign status     = q_head.status;
    assign out_byte   = q_head.out_byte;
    assign msg_length = q_head.msg_length;
    assign last       = q_head.last;

    // Free space never exceeds the ring
    `LPMR_ASSERT_NEVER(a_free_range, free_bytes_reg > FW'(RING_BYTES), "free space above ring size")
    // With nothing stored and nothing open, all space is free
    `LPMR_ASSERT(a_empty_free, (message_count_reg == '0 && push_left_reg == '0 && pop_left_reg == '0) |-> free_bytes_reg == FW'(RING_BYTES), "space lost with ring empty")
    // Store writes only while idle or writing a header
    `LPMR_ASSERT(a_wr_state, (state_reg != S_IDLE && state_reg != S_HDR_WR) |-> !mem_wr_en, "store written during a read")
    // A result only enters the queue when there is room
    `LPMR_ASSERT(a_q_room, q_push |-> q_space, "result queue overflow")

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for the length-prefixed message ring: a directed table, then random
// message traffic. Each reply is checked against its table entry or the ring model kept here.
// Depends on lpmr_pkg and the length_prefixed_message_ring RTL.
`default_nettype none

module tb;
    import lpmr_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RING_BYTES   = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int RAND_ITEMS   = 1700;
    localparam int RAND_CAP     = 12000;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 32;
    localparam int REPORT_MAX   = 10;
    localparam int PLAN_ROWS    = 26;

    // Action code with no meaning in the block
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;

    localparam rsp_t R_NONE = '0;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

    typedef struct packed {
        logic [2:0]  act;
        logic [7:0]  din;
        logic [12:0] cnt;
        logic        typed;
        rsp_t        res;
    } plan_row_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cmd_valid  = 1'b0;
    logic        cmd_stall;
    logic [2:0]  action     = ACT_CLEAR;
    logic [7:0]  data_byte  = 8'h00;
    logic [12:0] byte_count = 13'd0;
    logic        rsp_valid;
    logic        rsp_stall  = 1'b0;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [11:0] msg_length;
    logic        last;

    // Model of the ring
    logic [7:0] ring_copy [RING_BYTES];
    int rd_pos   = 0;
    int wr_pos   = 0;
    int free_cnt = RING_BYTES;
    int msg_cnt  = 0;
    int push_rem = 0;
    int pop_rem  = 0;

    // Run statistics
    int ring_wraps      = 0;
    int n_commit        = 0;
    int n_discard       = 0;
    int n_full          = 0;
    int n_empty         = 0;
    int items_sent      = 0;
    int tally           = 0;
    int results_checked = 0;
    int faults          = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;

    rsp_t pending_replies [$];
    plan_row_t plan [PLAN_ROWS];

    // Handshakes and reply payload sampled at the falling edge
    bit   cmd_take = 1'b0;
    bit   rsp_take = 1'b0;
    rsp_t rsp_seen;

    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    logic [15:0] stall_mask = '0;

    length_prefixed_message_ring i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .action     (action),
        .data_byte  (data_byte),
        .byte_count (byte_count),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .out_byte   (out_byte),
        .msg_length (msg_length),
        .last       (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one accepted item to the ring model and return the reply it earns
    function automatic rsp_t predict_ring_reply(input logic [2:0] act, input logic [7:0] din,
                                                input logic [12:0] cnt);
        rsp_t r;
        int hlen;
        int k;
        r = '0;
        r.status = STS_OK;
        case (act)
            ACT_PUSH_START:
            begin
                if (push_rem != 0)
                    r.status = STS_SEQ;
                else if (int'(cnt) + HEADER_BYTES > free_cnt)
                begin
                    r.status = STS_FULL;
                    n_full++;
                end
                else
                begin
                    // reserve the record and lay down the little-endian header
                    free_cnt -= int'(cnt) + HEADER_BYTES;
                    for (k = 0; k < HEADER_BYTES; k++)
                    begin
                        ring_copy[wr_pos] = 8'(int'(cnt) >> (8 * k));
                        wr_pos = (wr_pos + 1) % RING_BYTES;
                        if (wr_pos == 0)
                            ring_wraps++;
                    end
                    push_rem = int'(cnt);
                    if (push_rem == 0)
                    begin
                        msg_cnt++;
                        n_commit++;
                    end
                end
            end
            ACT_PUSH_BYTE:
            begin
                if (push_rem == 0)
                    r.status = STS_SEQ;
                else
                begin
                    ring_copy[wr_pos] = din;
                    wr_pos = (wr_pos + 1) % RING_BYTES;
                    if (wr_pos == 0)
                        ring_wraps++;
                    push_rem--;
                    if (push_rem == 0)
                    begin
                        msg_cnt++;
                        n_commit++;
                    end
                end
            end
            ACT_POP_HEADER:
            begin
                if (pop_rem != 0)
                    r.status = STS_SEQ;
                else if (msg_cnt == 0)
                begin
                    r.status = STS_EMPTY;
                    n_empty++;
                end
                else
                begin
                    hlen = 0;
                    for (k = 0; k < HEADER_BYTES; k++)
                        hlen |= int'(ring_copy[(rd_pos + k) % RING_BYTES]) << (8 * k);
                    msg_cnt--;
                    r.msg_length = 12'(hlen);
                    if (hlen > int'(cnt))
                    begin
                        // drop the whole record
                        rd_pos = (rd_pos + hlen + HEADER_BYTES) % RING_BYTES;
                        free_cnt += hlen + HEADER_BYTES;
                        r.status = STS_TOO_LARGE;
                        n_discard++;
                    end
                    else
                    begin
                        rd_pos = (rd_pos + HEADER_BYTES) % RING_BYTES;
                        free_cnt += HEADER_BYTES;
                        pop_rem = hlen;
                    end
                end
            end
            ACT_POP_BYTE:
            begin
                if (pop_rem == 0)
                    r.status = STS_SEQ;
                else
                begin
                    r.out_byte = ring_copy[rd_pos];
                    rd_pos = (rd_pos + 1) % RING_BYTES;
                    free_cnt++;
                    pop_rem--;
                    r.last = (pop_rem == 0);
                end
            end
            ACT_CLEAR:
            begin
                rd_pos   = 0;
                wr_pos   = 0;
                free_cnt = RING_BYTES;
                msg_cnt  = 0;
                push_rem = 0;
                pop_rem  = 0;
            end
            default:
                r.status = STS_SEQ;
        endcase
        return r;
    endfunction

    function automatic void log_fault(input string what, input rsp_t want, input rsp_t got);
        faults++;
        if (faults <= REPORT_MAX)
            $display("%s: want st=%0d byte=%02h len=%0d last=%0d, got st=%0d byte=%02h len=%0d last=%0d",
                     what, want.status, want.out_byte, want.msg_length, want.last,
                     got.status, got.out_byte, got.msg_length, got.last);
    endfunction

    // Offer one item in bursts with random gaps, then predict its reply once taken
    task automatic drive_item(input logic [2:0] act, input logic [7:0] din,
                              input logic [12:0] cnt, input logic typed, input rsp_t typed_res);
        rsp_t want;
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        action     <= act;
        data_byte  <= din;
        byte_count <= cnt;
        do
            @(posedge clk);
        while (!cmd_take);
        want = predict_ring_reply(act, din, cnt);
        items_sent++;
        if (want.status != STS_SEQ)
            tally++;
        pending_replies.push_back(typed ? typed_res : want);
    endtask

    // Stall the reply channel in phases: none, light, a repeating mask, heavy
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
            stall_mask = 16'($urandom) & 16'hFFFE;
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:    rsp_stall <= 1'b0;
            STALL_LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PATTERN: rsp_stall <= stall_mask[stall_left % 16];
            default:       rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Check the reply taken at the edge just passed, then sample for the next edge
    always @(negedge clk)
    begin
        rsp_t want;
        if (rsp_take)
        begin
            if (pending_replies.size() == 0)
                log_fault("reply with nothing pending", R_NONE, rsp_seen);
            else
            begin
                want = pending_replies.pop_front();
                results_checked++;
                if (want.status !== rsp_seen.status || want.out_byte !== rsp_seen.out_byte ||
                    want.msg_length !== rsp_seen.msg_length || want.last !== rsp_seen.last)
                    log_fault("reply mismatch", want, rsp_seen);
            end
        end
        cmd_take = rst_n && cmd_valid && !cmd_stall;
        rsp_take = rst_n && rsp_valid && !rsp_stall;
        rsp_seen = {status, out_byte, msg_length, last};
        // watchdog on handshake progress
        if (rst_n && !cmd_take && !rsp_take)
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no handshake for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]  act;
        logic [7:0]  din;
        logic [12:0] cnt;
        int roll;
        int pick;
        int hlen;
        int lo;
        int k;
        int fill_pct;

        plan = '{
            // empty ring, nothing open, spare code
            '{ACT_POP_HEADER, 8'h00, 13'd0,    1'b1, '{STS_EMPTY, 8'h00, 12'd0, 1'b0}},
            '{ACT_POP_BYTE,   8'h00, 13'd0,    1'b1, '{STS_SEQ,   8'h00, 12'd0, 1'b0}},
            '{ACT_PUSH_BYTE,  8'hFF, 13'd0,    1'b1, '{STS_SEQ,   8'h00, 12'd0, 1'b0}},
            '{ACT_SPARE_LO,   8'hFF, 13'h1FFF, 1'b1, '{STS_SEQ,   8'h00, 12'd0, 1'b0}},
            // one past the largest fit, and every count bit set
            '{ACT_PUSH_START, 8'h00, 13'd4093, 1'b1, '{STS_FULL,  8'h00, 12'd0, 1'b0}},
            '{ACT_PUSH_START, 8'h00, 13'h1FFF, 1'b1, '{STS_FULL,  8'h00, 12'd0, 1'b0}},
            // empty message commits at once and opens no pop
            '{ACT_PUSH_START, 8'h00, 13'd0,    1'b1, '{STS_OK,    8'h00, 12'd0, 1'b0}},
            '{ACT_POP_HEADER, 8'h00, 13'd0,    1'b1, '{STS_OK,    8'h00, 12'd0, 1'b0}},
            '{ACT_POP_BYTE,   8'h00, 13'd0,    1'b1, '{STS_SEQ,   8'h00, 12'd0, 1'b0}},
            // largest message, a second start while open, then clear
            '{ACT_PUSH_START, 8'h00, 13'd4092, 1'b1, '{STS_OK,    8'h00, 12'd0, 1'b0}},
            '{ACT_PUSH_START, 8'h00, 13'd1,    1'b1, '{STS_SEQ,   8'h00, 12'd0, 1'b0}},
            '{ACT_PUSH_BYTE,  8'hFF, 13'd0,    1'b0, R_NONE},
            '{ACT_CLEAR,      8'h00, 13'd0,    1'b1, '{STS_OK,    8'h00, 12'd0, 1'b0}},
            '{ACT_POP_HEADER, 8'h00, 13'h1FFF, 1'b1, '{STS_EMPTY, 8'h00, 12'd0, 1'b0}},
            // two short messages
            '{ACT_PUSH_START, 8'h00, 13'd3,    1'b0, R_NONE},
            '{ACT_PUSH_BYTE,  8'h00, 13'd0,    1'b0, R_NONE},
            '{ACT_PUSH_BYTE,  8'hFF, 13'd0,    1'b0, R_NONE},
            '{ACT_PUSH_BYTE,  8'hA5, 13'd0,    1'b0, R_NONE},
            '{ACT_PUSH_START, 8'h00, 13'd2,    1'b0, R_NONE},
            '{ACT_PUSH_BYTE,  8'h5A, 13'd0,    1'b0, R_NONE},
            '{ACT_PUSH_BYTE,  8'h3C, 13'd0,    1'b0, R_NONE},
            // reader too small: discard the first, read the second
            '{ACT_POP_HEADER, 8'h00, 13'd2,    1'b1, '{STS_TOO_LARGE, 8'h00, 12'd3, 1'b0}},
            '{ACT_POP_HEADER, 8'h00, 13'h1FFF, 1'b0, R_NONE},
            '{ACT_POP_HEADER, 8'h00, 13'd0,    1'b1, '{STS_SEQ,   8'h00, 12'd0, 1'b0}},
            '{ACT_POP_BYTE,   8'h00, 13'd0,    1'b0, R_NONE},
            '{ACT_POP_BYTE,   8'h00, 13'd0,    1'b0, R_NONE}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < PLAN_ROWS; k++)
            drive_item(plan[k].act, plan[k].din, plan[k].cnt, plan[k].typed, plan[k].res);

        // Random traffic: mostly whole messages, some noise; empty records flood the
        // ring until the write position first wraps, then the mix evens out
        while (tally < RAND_ITEMS && items_sent < RAND_CAP)
        begin
            roll = $urandom_range(0, 999);
            act = 3'($urandom);
            din = 8'($urandom);
            cnt = 13'($urandom);
            if (ring_wraps == 0)
                fill_pct = 90;
            else
                fill_pct = ((items_sent / 150) % 2 == 0) ? 75 : 35;
            if (roll < 40)
            begin
                // noise; keep clear out and push any start that would fit past the ring size
                if (act == ACT_CLEAR)
                    act = ACT_SPARE_LO;
                if (act == ACT_PUSH_START)
                    cnt[12] = 1'b1;
            end
            else if (roll < 42 && ring_wraps != 0)
                act = ACT_CLEAR;
            else
            begin
                if (push_rem != 0 && pop_rem != 0)
                    act = ($urandom_range(0, 1) != 0) ? ACT_PUSH_BYTE : ACT_POP_BYTE;
                else if (push_rem != 0)
                    act = (msg_cnt != 0 && roll < 150) ? ACT_POP_HEADER : ACT_PUSH_BYTE;
                else if (pop_rem != 0)
                    act = (roll < 200) ? ACT_PUSH_START : ACT_POP_BYTE;
                else if (msg_cnt == 0)
                    act = (roll < 90) ? ACT_POP_HEADER : ACT_PUSH_START;
                else
                    act = ($urandom_range(0, 99) < fill_pct) ? ACT_PUSH_START : ACT_POP_HEADER;

                if (act == ACT_PUSH_START)
                begin
                    pick = $urandom_range(0, 99);
                    lo = (free_cnt > HEADER_BYTES) ? free_cnt - HEADER_BYTES + 1 : 0;
                    if (pick < 30 || (ring_wraps == 0 && pick < 97))
                        cnt = '0;
                    else if (pick < 80)
                        cnt = 13'($urandom_range(1, 6));
                    else if (pick < 93)
                        cnt = 13'($urandom_range(7, 64));
                    else if (pick < 95)
                        cnt = 13'($urandom_range(65, 400));
                    else if (pick < 98 || free_cnt < HEADER_BYTES || free_cnt > 300)
                        cnt = 13'($urandom_range(lo, 8191));
                    else
                        cnt = 13'(free_cnt - HEADER_BYTES);
                end
                else if (act == ACT_POP_HEADER && msg_cnt != 0 && pop_rem == 0)
                begin
                    // size the reader against the head length
                    hlen = 0;
                    for (k = 0; k < HEADER_BYTES; k++)
                        hlen |= int'(ring_copy[(rd_pos + k) % RING_BYTES]) << (8 * k);
                    pick = $urandom_range(0, 99);
                    if (pick < 35 && hlen > 0)
                        cnt = 13'($urandom_range(0, hlen - 1));
                    else if (pick < 95)
                        cnt = 13'(hlen + $urandom_range(0, 16));
                end
            end
            drive_item(act, din, cnt, 1'b0, R_NONE);
        end
        cmd_valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("items %0d (%0d acted on), replies checked %0d, ring wraps %0d",
                 items_sent, tally, results_checked, ring_wraps);
        $display("messages committed %0d, discarded %0d, full rejects %0d, empty polls %0d",
                 n_commit, n_discard, n_full, n_empty);
        if (faults == 0 && pending_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> length_prefixed_message_ring.f
+incdir+sv
sv/lpmr_pkg.sv
sv/lpmr_ram.sv
sv/lpmr_out_q.sv
sv/length_prefixed_message_ring.sv
test/tb.sv
